// File: rtl/page_translate_fifo_replace_core_assert.svh
// Assertion macros for the page translation core.
`ifndef PAGE_TRANSLATE_FIFO_REPLACE_CORE_ASSERT_SVH
`define PAGE_TRANSLATE_FIFO_REPLACE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, clocked on clk, held off in reset.
`define PTFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, clocked on clk, held off in reset.
`define PTFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTFR_ASSERT_IMP(lbl, ante, cons, msg)
`define PTFR_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/ptfr_pkg.sv
// Shared constants and helpers for the page translation core.
package ptfr_pkg;

    localparam int VA_W           = 16;
    localparam int PAGE_BYTES     = 32;
    localparam int OFFSET_W       = $clog2(PAGE_BYTES);
    localparam int PAGE_W         = VA_W - OFFSET_W;
    localparam int NUM_FRAMES_DEF = 16;

    // Result field widths
    localparam int FRAME_W    = 4;
    localparam int PHYS_W     = 9;
    localparam int PAGE_OUT_W = 11;
    localparam int COUNT_W    = 32;

    localparam int OUT_FIELDS_W = 1 + FRAME_W + PHYS_W + 1 + PAGE_OUT_W + 1 + PAGE_OUT_W
                                  + COUNT_W + COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // Operation codes carried on tuser
    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_CLEAR     = 1'b1;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

// File: rtl/page_translate_fifo_replace_core.sv
// Top level: fully associative page translation with FIFO frame replacement.
//
//  channel   | dir | tdata                          | tuser
//  ----------+-----+--------------------------------+-----------
//  s_axis    | in  | virtual_address[15:0]          | op[0]
//  m_axis    | out | hit, frame, physical_address,  | -
//            |     | evict_valid, evicted_page,     |
//            |     | fill_valid, fill_page,         |
//            |     | reference_count, fault_count   |
//
// Sequence: a translation that hits frame k passes accept, scan steps up to
//   frame k, result; a fault passes accept, full scan, replacement update,
//   result. A clear passes accept and result. The scan reads one table entry
//   a cycle through the single read port and one shared page comparator.
// Reset: valid flags and counters clear at once; no clearing pass is needed.
// Stalls: one transaction in flight; s_axis_tready is low from accept until the
//   result moves into the output register, which frees when m_axis_tready is seen.
`include "page_translate_fifo_replace_core_assert.svh"

module page_translate_fifo_replace_core #(
    parameter int NUM_FRAMES = ptfr_pkg::NUM_FRAMES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] virtual_address
    input  logic [ptfr_pkg::VA_W-1:0]        s_axis_tdata,
    // [0] op
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] hit, [4:1] frame, [13:5] physical_address, [14] evict_valid,
    // [25:15] evicted_page, [26] fill_valid, [37:27] fill_page,
    // [69:38] reference_count, [101:70] fault_count, [103:102] zero
    output logic [ptfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import ptfr_pkg::*;

    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FRAMES - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;       // scan position
    logic [IDX_W-1:0]     ptr_reg, ptr_next;       // FIFO replace pointer
    logic [PAGE_W-1:0]    page_reg, page_next;
    logic [OFFSET_W-1:0]  offset_reg, offset_next;
    logic [COUNT_W-1:0]   ref_reg, ref_next;
    logic [COUNT_W-1:0]   fault_reg, fault_next;
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     frame_reg, frame_next;
    logic                 evict_reg, evict_next;
    logic [PAGE_W-1:0]    evpage_reg, evpage_next;
    logic                 fill_reg, fill_next;
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    // table port
    logic [IDX_W-1:0]     tbl_rd_idx;
    logic                 tbl_rd_valid;
    logic [PAGE_W-1:0]    tbl_rd_page;
    logic                 tbl_wr_en;

    // result assembly
    logic [31:0]          frame_w32, phys_w32, evpage_w32, page_w32;
    logic [PAGE_OUT_W-1:0] res_fill_page;
    logic [OUT_TDATA_W-1:0] result_word;
    logic                 page_match;

    ptfr_table #(
        .NUM_FRAMES (NUM_FRAMES),
        .IDX_W      (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (tbl_rd_idx),
        .rd_valid (tbl_rd_valid),
        .rd_page  (tbl_rd_page),
        .wr_en    (tbl_wr_en),
        .wr_idx   (ptr_reg),
        .wr_page  (page_reg)
    );

    // Shared comparator: one entry per scan step
    assign page_match = tbl_rd_valid && (tbl_rd_page == page_reg);

    // Field widths are fixed; wider indices or pages are masked
    assign frame_w32  = 32'(frame_reg);
    assign phys_w32   = (32'(frame_reg) << OFFSET_W) | 32'(offset_reg);
    assign evpage_w32 = 32'(evpage_reg);
    assign page_w32   = 32'(page_reg);
    assign res_fill_page = fill_reg ? page_w32[PAGE_OUT_W-1:0] : '0;

    assign result_word = {
        {OUT_PAD_W{1'b0}},
        fault_reg,
        ref_reg,
        res_fill_page,
        fill_reg,
        evpage_w32[PAGE_OUT_W-1:0],
        evict_reg,
        phys_w32[PHYS_W-1:0],
        frame_w32[FRAME_W-1:0],
        hit_reg
    };

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        ptr_next     = ptr_reg;
        page_next    = page_reg;
        offset_next  = offset_reg;
        ref_next     = ref_reg;
        fault_next   = fault_reg;
        hit_next     = hit_reg;
        frame_next   = frame_reg;
        evict_next   = evict_reg;
        evpage_next  = evpage_reg;
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        tbl_wr_en    = 1'b0;

        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    hit_next    = 1'b0;
                    evict_next  = 1'b0;
                    evpage_next = '0;
                    fill_next   = 1'b0;
                    if (s_axis_tuser[0] == OP_CLEAR)
                    begin
                        ref_next    = '0;
                        fault_next  = '0;
                        frame_next  = '0;
                        offset_next = '0;
                        state_next  = ST_RESULT;
                    end
                    else
                    begin
                        ref_next    = sat_inc(ref_reg);
                        page_next   = s_axis_tdata[VA_W-1:OFFSET_W];
                        offset_next = s_axis_tdata[OFFSET_W-1:0];
                        idx_next    = '0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (page_match)
                begin
                    // lowest matching frame wins
                    hit_next   = 1'b1;
                    frame_next = idx_reg;
                    state_next = ST_RESULT;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    // miss: fetch the victim entry for the update step
                    idx_next   = ptr_reg;
                    state_next = ST_UPDATE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_UPDATE:
            begin
                frame_next  = ptr_reg;
                evict_next  = tbl_rd_valid;
                evpage_next = tbl_rd_valid ? tbl_rd_page : '0;
                fill_next   = 1'b1;
                fault_next  = sat_inc(fault_reg);
                tbl_wr_en   = 1'b1;
                ptr_next    = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
                state_next  = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = result_word;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // read address runs one step ahead of the compare
        tbl_rd_idx = idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            ptr_reg     <= '0;
            ref_reg     <= '0;
            fault_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            ptr_reg     <= ptr_next;
            ref_reg     <= ref_next;
            fault_reg   <= fault_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        page_reg   <= page_next;
        offset_reg <= offset_next;
        hit_reg    <= hit_next;
        frame_reg  <= frame_next;
        evict_reg  <= evict_next;
        evpage_reg <= evpage_next;
        fill_reg   <= fill_next;
        m_data_reg <= m_data_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // A hit never carries write-back or fill
    `PTFR_ASSERT_IMP(a_hit_no_xfer, (state_reg == ST_RESULT) && hit_reg, !evict_reg && !fill_reg, "hit with eviction or fill")
    // Faults only ever count alongside references
    `PTFR_ASSERT_IMP(a_fault_le_ref, 1'b1, fault_reg <= ref_reg, "fault count above reference count")
    // Once a transaction is taken the block is busy
    `PTFR_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")

endmodule

// File: rtl/ptfr_table.sv
// Resident page table: page memory with per-frame valid flags, one read and one write port.
module ptfr_table #(
    parameter int NUM_FRAMES = ptfr_pkg::NUM_FRAMES_DEF,
    parameter int IDX_W      = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [IDX_W-1:0]          rd_idx,
    output logic                      rd_valid,
    output logic [ptfr_pkg::PAGE_W-1:0] rd_page,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_idx,
    input  logic [ptfr_pkg::PAGE_W-1:0] wr_page
);
    import ptfr_pkg::*;

    logic [PAGE_W-1:0]     page_mem [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] valid_reg;
    logic [PAGE_W-1:0]     rd_page_reg;
    logic                  rd_valid_reg;

    // Page store: no reset, guarded by the valid flags
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            page_mem[wr_idx] <= wr_page;
        end
        rd_page_reg <= page_mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    assign rd_page  = rd_page_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the page translation core with FIFO frame replacement.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ptfr_pkg::*;

    // Timing
    localparam int  CLK_HALF      = 4;
    localparam int  RESET_CYCLES  = 12;
    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  DRAIN_CYCLES  = 40;
    localparam int  HOLD_CYCLES   = 600;
    localparam int  HOLD_TRIGGER  = 120;
    localparam int  MAX_REPORTS   = 10;

    // Stimulus shape
    localparam int  RANDOM_PER_PHASE = 367;
    localparam int  HOT_SET_SIZE     = 24;

    // One input transaction: op on tuser, virtual address on tdata
    typedef struct {
        logic            op;
        logic [VA_W-1:0] va;
    } access_t;

    // One result transaction, packed so that hit sits at bit 0 as on m_axis_tdata
    typedef struct packed {
        logic [COUNT_W-1:0]    fault_count;
        logic [COUNT_W-1:0]    reference_count;
        logic [PAGE_OUT_W-1:0] fill_page;
        logic                  fill_valid;
        logic [PAGE_OUT_W-1:0] evicted_page;
        logic                  evict_valid;
        logic [PHYS_W-1:0]     physical_address;
        logic [FRAME_W-1:0]    frame;
        logic                  hit;
    } translation_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [VA_W-1:0]        s_axis_tdata = '0;
    logic [0:0]             s_axis_tuser = OP_TRANSLATE;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    page_translate_fifo_replace_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the page table, FIFO pointer and
    // the two saturating counters.
    // ------------------------------------------------------------------
    logic                  frame_used   [NUM_FRAMES_DEF];
    logic [PAGE_W-1:0]     frame_page   [NUM_FRAMES_DEF];
    logic [FRAME_W-1:0]    fifo_ptr;
    logic [COUNT_W-1:0]    refs_so_far;
    logic [COUNT_W-1:0]    faults_so_far;

    access_t      pending_accesses[$];
    translation_t expected_translations[$];

    int  send_idle_pct = 37;
    int  recv_idle_pct = 58;
    int  accesses_accepted = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    access_t next_access;

    logic [PAGE_W-1:0] hot_pages[HOT_SET_SIZE];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Works out the result of one accepted transaction and updates the
    // predicted table. Lowest matching frame wins, though a correct table
    // never holds a page twice.
    function automatic translation_t translate_page(input logic op, input logic [VA_W-1:0] va);
        translation_t       res;
        logic [PAGE_W-1:0]  page;
        logic [OFFSET_W-1:0] offset;
        bit                 found;
        logic [FRAME_W-1:0] slot;

        res    = '0;
        page   = va[VA_W-1:OFFSET_W];
        offset = va[OFFSET_W-1:0];
        found  = 1'b0;
        slot   = '0;

        if (op == OP_CLEAR)
        begin
            refs_so_far   = '0;
            faults_so_far = '0;
            return res;
        end

        if (refs_so_far != '1)
            refs_so_far = refs_so_far + 1'b1;

        for (int i = 0; i < NUM_FRAMES_DEF; i++)
        begin
            if (!found && frame_used[i] && frame_page[i] == page)
            begin
                found = 1'b1;
                slot  = FRAME_W'(i);
            end
        end

        if (found)
            res.hit = 1'b1;
        else
        begin
            if (faults_so_far != '1)
                faults_so_far = faults_so_far + 1'b1;
            slot     = fifo_ptr;
            fifo_ptr = fifo_ptr + 1'b1;     // wraps at sixteen frames
            if (frame_used[slot])
            begin
                res.evict_valid  = 1'b1;
                res.evicted_page = frame_page[slot];
            end
            res.fill_valid   = 1'b1;
            res.fill_page    = page;
            frame_used[slot] = 1'b1;
            frame_page[slot] = page;
        end

        res.frame            = slot;
        res.physical_address = PHYS_W'(slot * PAGE_BYTES + offset);
        res.reference_count  = refs_so_far;
        res.fault_count      = faults_so_far;
        return res;
    endfunction

    // Compares one result transaction with the oldest prediction
    function automatic void check_translation(input logic [OUT_TDATA_W-1:0] raw);
        translation_t got;
        translation_t want;
        bit           bad;

        got = raw[OUT_FIELDS_W-1:0];
        if (expected_translations.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: result with nothing expected: %h", $realtime, raw);
            return;
        end
        want = expected_translations.pop_front();
        bad  = (got.hit != want.hit) || (got.frame != want.frame)
               || (got.physical_address != want.physical_address)
               || (got.evict_valid != want.evict_valid)
               || (got.evicted_page != want.evicted_page)
               || (got.fill_valid != want.fill_valid)
               || (got.fill_page != want.fill_page)
               || (got.reference_count != want.reference_count)
               || (got.fault_count != want.fault_count)
               || (raw[OUT_TDATA_W-1:OUT_FIELDS_W] != '0);
        if (bad)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
            begin
                $display("%0t: mismatch hit %0d/%0d frame %0d/%0d pa %0d/%0d ev %0d:%0d/%0d:%0d",
                         $realtime, got.hit, want.hit, got.frame, want.frame,
                         got.physical_address, want.physical_address,
                         got.evict_valid, got.evicted_page,
                         want.evict_valid, want.evicted_page);
                $display("    fill %0d:%0d/%0d:%0d refs %0d/%0d faults %0d/%0d pad %b",
                         got.fill_valid, got.fill_page, want.fill_valid, want.fill_page,
                         got.reference_count, want.reference_count,
                         got.fault_count, want.fault_count,
                         raw[OUT_TDATA_W-1:OUT_FIELDS_W]);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents the next pending access whenever the bus is free,
    // idling at random; predicts each transaction as it is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= OP_TRANSLATE;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_translations.push_back(translate_page(s_axis_tuser[0], s_axis_tdata));
                accesses_accepted <= accesses_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_access = pending_accesses.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_access.va;
                    s_axis_tuser  <= next_access.op;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, checks every result transaction.
    // During the long hold-off tready stays low so the core fills and
    // drops s_axis_tready while the driver keeps offering.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_translation(m_axis_tdata);
            m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off, counted in its own process
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && accesses_accepted >= HOLD_TRIGGER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_access(input logic op, input logic [VA_W-1:0] va);
        access_t a;
        a.op = op;
        a.va = va;
        pending_accesses.push_back(a);
    endtask

    // Mostly a hot set slightly larger than the table, so hits, faults and
    // evictions all occur; the rest are stray addresses and counter clears.
    task automatic queue_random_accesses(input int count);
        int pick;
        for (int i = 0; i < HOT_SET_SIZE; i++)
            hot_pages[i] = PAGE_W'($urandom);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 5)
                hot_pages[$urandom_range(0, HOT_SET_SIZE - 1)] = PAGE_W'($urandom);
            if (pick < 4)
                queue_access(OP_CLEAR, VA_W'($urandom));
            else if (pick < 14)
                queue_access(OP_TRANSLATE, VA_W'($urandom));
            else
                queue_access(OP_TRANSLATE,
                             {hot_pages[$urandom_range(0, HOT_SET_SIZE - 1)],
                              OFFSET_W'($urandom)});
        end
    endtask

    // Sender pause: nothing more goes out until every result is back
    task automatic wait_for_drain();
        while (pending_accesses.size() != 0 || s_axis_tvalid
               || expected_translations.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence. Shared variables only change at the falling edge.
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < NUM_FRAMES_DEF; i++)
        begin
            frame_used[i] = 1'b0;
            frame_page[i] = '0;
        end
        fifo_ptr      = '0;
        refs_so_far   = '0;
        faults_so_far = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part
        queue_access(OP_CLEAR, 16'hFFFF);               // clear on an idle table
        queue_access(OP_TRANSLATE, 16'h0000);           // lowest address, first fault
        queue_access(OP_TRANSLATE, 16'h001F);           // same page, top offset: hit
        queue_access(OP_TRANSLATE, 16'hFFFF);           // highest page and offset
        queue_access(OP_TRANSLATE, 16'hFFE0);           // hit in frame one
        for (int k = 1; k <= NUM_FRAMES_DEF - 2; k++)   // fill the remaining frames
            queue_access(OP_TRANSLATE, {PAGE_W'(k), OFFSET_W'(k * 7)});
        queue_access(OP_TRANSLATE, {PAGE_W'(100), 5'h15});  // evicts page in frame zero
        queue_access(OP_TRANSLATE, 16'h0000);           // refault, evicts page 2047
        queue_access(OP_TRANSLATE, {PAGE_W'(14), 5'h0A});   // hit in the last frame
        queue_access(OP_CLEAR, 16'hAAAA);               // clear with a populated table
        queue_access(OP_TRANSLATE, 16'h5555);
        wait_for_drain();

        // Receiver idles more than sender
        queue_random_accesses(RANDOM_PER_PHASE);
        wait_for_drain();

        // Sender idles more than receiver
        send_idle_pct = 58;
        recv_idle_pct = 37;
        queue_random_accesses(RANDOM_PER_PHASE);
        wait_for_drain();

        // Full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_accesses(RANDOM_PER_PHASE);
        wait_for_drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_translations.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
